// ===== hdl/adsr_pkg.sv =====
// adsr_pkg: shared types and constants for the adsr envelope generator
// no dependencies; imported by adsr_mac and adsr_envelope_generator
package adsr_pkg;

    localparam int LVL_W  = 17;           // unsigned q1.16 level
    localparam int PH_W   = 16;           // q0.16 phase
    localparam int GATE_W = 18;           // signed q2.16 gate
    localparam int STEP_W = 17;           // phase step register
    localparam int ACC_W  = 34;           // sum of two 17x17 products
    localparam int CFG_IDX_W = 2;

    localparam logic [LVL_W-1:0] LVL_ONE = 17'h10000;
    localparam logic [ACC_W-1:0] ACC_HALF = 34'h8000;
    localparam logic signed [GATE_W-1:0] GATE_HALF = 18'sh08000;
    localparam logic [STEP_W-1:0] STEP_RST = 17'd65;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_ADV,
        SQ_SQUARE,
        SQ_SHAPE,
        SQ_MCAP,
        SQ_MREST,
        SQ_LEVEL,
        SQ_OUT
    } t_seq;

    typedef struct packed {
        logic signed [GATE_W-1:0] gate_level;
        logic [LVL_W-1:0]         sustain_level;
    } t_in_word;

    typedef struct packed {
        logic [LVL_W-1:0] envelope_level;
        logic [2:0]       stage_now;
    } t_out_word;

    // multiply-accumulate control
    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

    function automatic logic [LVL_W-1:0] clamp_one(input logic [ACC_W-1:0] v);
        clamp_one = (v > ACC_W'(LVL_ONE)) ? LVL_ONE : v[LVL_W-1:0];
    endfunction

endpackage

// ===== hdl/adsr_mac.sv =====
// adsr_mac: shared 17x17 multiplier with registered accumulator
// depends on adsr_pkg
module adsr_mac (
    input  logic                         i_clk,
    input  adsr_pkg::t_mac_ctl           i_ctl,
    input  logic [adsr_pkg::LVL_W-1:0]   i_a,
    input  logic [adsr_pkg::LVL_W-1:0]   i_b,
    output logic [adsr_pkg::ACC_W-1:0]   o_acc
);
    import adsr_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] w_prod;

    assign w_prod = ACC_W'(i_a) * ACC_W'(i_b);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.en) begin
            n_acc = i_ctl.clr ? w_prod : r_acc + w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/adsr_envelope_generator.sv =====
// adsr_envelope_generator: top level of the per-sample adsr envelope
// depends on adsr_pkg and adsr_mac
//
// usage
//  - input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//    audio sample: signed q2.16 gate and q1.16 sustain target
//  - output channel (o_out_valid / i_out_ready / o_out_word) returns one word
//    per input word: envelope level (q1.16) and the stage after the update
//  - i_cfg_we / i_cfg_idx / i_cfg_data write the attack, decay and release
//    phase steps; write them only while no sample is in flight
//  - mid-curve, a sample passes phase advance, square, two multiply-accumulates
//    and rounding before the result register; when a stage ends or holds it
//    goes from phase advance to the output step; all products go through the
//    single 17x17 multiply-accumulate unit, which sets the rate
//  - o_in_ready is high only while the sequencer is idle, so the block takes
//    no new sample until the previous one has left the output step
//  - the result register holds a finished word while the receiver stalls;
//    the sequencer waits in its last step until that register is free
//  - synchronous active-low reset: stage idle, level, capture and phase zero,
//    all steps 65, no result pending
module adsr_envelope_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  adsr_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output adsr_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adsr_pkg::STEP_W-1:0]       i_cfg_data
);
    import adsr_pkg::*;

    // sequencer and envelope state
    t_seq   r_seq, n_seq;
    t_stage r_stage;
    logic [PH_W-1:0]   r_phase;
    logic [LVL_W-1:0]  r_cap;
    logic [LVL_W-1:0]  r_cur;
    logic [LVL_W-1:0]  r_sus;        // clamped sustain of the current sample
    logic [LVL_W-1:0]  r_shape;      // (1 - phase)^2
    logic [STEP_W-1:0] r_att_step, r_dec_step, r_rel_step;

    // result register
    logic      r_out_valid;
    t_out_word r_out_word;

    // handshake and datapath controls
    logic     w_in_acc;
    logic     w_out_load;
    t_mac_ctl w_mac_ctl;
    logic [LVL_W-1:0] w_mac_a, w_mac_b;
    logic [ACC_W-1:0] w_acc;

    // phase advance
    logic [STEP_W-1:0] w_step_raw, w_step;
    logic [STEP_W:0]   w_phase_sum;
    logic              w_stage_end;
    logic              w_curving;

    // derived values
    logic [ACC_W-1:0] w_rounded;
    logic [LVL_W-1:0] w_q;
    logic [LVL_W-1:0] w_sus_clamped;
    logic             w_active;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_seq == SQ_OUT) && (!r_out_valid || i_out_ready);

    assign w_sus_clamped = clamp_one(ACC_W'(i_in_word.sustain_level));
    assign w_active = (r_stage == ST_ATTACK) || (r_stage == ST_DECAY)
                   || (r_stage == ST_SUSTAIN);

    // step of the running stage, zero acts as one
    always_comb begin
        case (r_stage)
            ST_ATTACK:  w_step_raw = r_att_step;
            ST_DECAY:   w_step_raw = r_dec_step;
            ST_RELEASE: w_step_raw = r_rel_step;
            default:    w_step_raw = '0;
        endcase
    end
    assign w_step      = (w_step_raw == '0) ? STEP_W'(1) : w_step_raw;
    assign w_phase_sum = (STEP_W+1)'(r_phase) + (STEP_W+1)'(w_step);
    assign w_stage_end = (w_phase_sum[STEP_W:PH_W] != '0);
    assign w_curving   = ((r_stage == ST_ATTACK) || (r_stage == ST_DECAY)
                       || (r_stage == ST_RELEASE)) && !w_stage_end;

    assign w_q       = LVL_ONE - LVL_W'(r_phase);
    assign w_rounded = w_acc + ACC_HALF;

    // next sequencer step
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE:   if (w_in_acc) n_seq = SQ_ADV;
            SQ_ADV:    n_seq = w_curving ? SQ_SQUARE : SQ_OUT;
            SQ_SQUARE: n_seq = SQ_SHAPE;
            SQ_SHAPE:  n_seq = SQ_MCAP;
            SQ_MCAP:   n_seq = SQ_MREST;
            SQ_MREST:  n_seq = SQ_LEVEL;
            SQ_LEVEL:  n_seq = SQ_OUT;
            SQ_OUT:    if (w_out_load) n_seq = SQ_IDLE;
            default:   n_seq = SQ_IDLE;
        endcase
    end

    // sequencer outputs: ready and multiplier operands
    always_comb begin
        o_in_ready    = 1'b0;
        w_mac_ctl.en  = 1'b0;
        w_mac_ctl.clr = 1'b0;
        w_mac_a       = w_q;
        w_mac_b       = w_q;
        unique case (r_seq)
            SQ_IDLE: begin
                o_in_ready = 1'b1;
            end
            SQ_SQUARE: begin
                // (1 - phase)^2
                w_mac_ctl.en  = 1'b1;
                w_mac_ctl.clr = 1'b1;
            end
            SQ_MCAP: begin
                w_mac_ctl.en  = 1'b1;
                w_mac_ctl.clr = 1'b1;
                w_mac_a       = clamp_one(ACC_W'(r_cap));
                w_mac_b       = r_shape;
            end
            SQ_MREST: begin
                // target level times the remaining weight
                w_mac_ctl.en = 1'b1;
                w_mac_b      = LVL_ONE - r_shape;
                case (r_stage)
                    ST_ATTACK: w_mac_a = LVL_ONE;
                    ST_DECAY:  w_mac_a = r_sus;
                    default:   w_mac_a = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    adsr_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_acc)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_step <= STEP_RST;
            r_dec_step <= STEP_RST;
            r_rel_step <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_att_step <= i_cfg_data;
                CFG_DECAY:   r_dec_step <= i_cfg_data;
                CFG_RELEASE: r_rel_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            r_phase <= '0;
            r_cap   <= '0;
            r_cur   <= '0;
        end else begin
            case (r_seq)
                SQ_IDLE: begin
                    // gate decision
                    if (w_in_acc) begin
                        r_sus <= w_sus_clamped;
                        if (w_active) begin
                            if (i_in_word.gate_level < GATE_HALF) begin
                                r_stage <= ST_RELEASE;
                                r_phase <= '0;
                                r_cap   <= r_cur;
                            end
                        end else if (i_in_word.gate_level > GATE_HALF) begin
                            r_stage <= ST_ATTACK;
                            r_phase <= '0;
                            r_cap   <= r_cur;
                        end
                    end
                end
                SQ_ADV: begin
                    if (r_stage == ST_SUSTAIN) begin
                        r_cur <= r_sus;
                    end else if (w_curving) begin
                        r_phase <= w_phase_sum[PH_W-1:0];
                    end else if (w_stage_end) begin
                        r_phase <= '0;
                        case (r_stage)
                            ST_ATTACK: begin
                                r_cap   <= r_cur;
                                r_stage <= ST_DECAY;
                            end
                            ST_DECAY: begin
                                r_cur   <= r_sus;
                                r_stage <= ST_SUSTAIN;
                            end
                            default: begin
                                r_cur   <= '0;
                                r_cap   <= '0;
                                r_stage <= ST_IDLE;
                            end
                        endcase
                    end
                end
                SQ_SHAPE: begin
                    r_shape <= w_rounded[LVL_W+PH_W-1:PH_W];
                end
                SQ_LEVEL: begin
                    r_cur <= clamp_one(w_rounded >> PH_W);
                end
                default: begin
                end
            endcase
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word.envelope_level <= r_cur;
            r_out_word.stage_now      <= r_stage;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // one sample at a time: no second word right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input accepted while a sample was in flight");

    // level never exceeds full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= LVL_ONE) && (r_cap <= LVL_ONE))
        else $error("envelope level above full scale");

    // idle is reached only with a cleared envelope
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_IDLE) |-> (r_cur == '0) && (r_cap == '0) && (r_phase == '0))
        else $error("idle stage with nonzero envelope state");

    // a result is loaded only from the last sequencer step
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_seq) == SQ_OUT)
        else $error("result loaded outside the output step");
`endif

endmodule
